// ----- rtl/core/tbv_pkg.sv -----
// Shared types, constants and helpers for the triangle bounding-box voxelizer.
// No dependencies; every rtl/core module imports this package.
`timescale 1ns / 1ps
package tbv_pkg;
   localparam int MaxWidth  = 16;
   localparam int MaxHeight = 16;
   localparam int MaxDepth  = 16;
   localparam int StoreSize = MaxWidth * MaxHeight * MaxDepth;
   localparam int IdxW      = $clog2(StoreSize);
   localparam int XW        = $clog2(MaxWidth);
   localparam int YW        = $clog2(MaxHeight);
   localparam int ZW        = $clog2(MaxDepth);
   localparam int CntW      = 13;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NOP    = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_INV_CELL = 3'd3,
      CSR_WIDTH    = 3'd4,
      CSR_HEIGHT   = 3'd5,
      CSR_DEPTH    = 3'd6,
      CSR_NONE     = 3'd7
   } csr_index_type;

   // Classified work handed from front to back.
   typedef struct packed {
      req_type_type  kind;
      logic          empty_box;
      logic [XW-1:0] xl, xh;
      logic [YW-1:0] yl, yh;
      logic [ZW-1:0] zl, zh;
      logic [IdxW:0] w;
      logic [IdxW:0] wh;
      logic [IdxW-1:0] qidx;
      logic          qbad;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_WALK, BK_QUERY, BK_CLEAR, BK_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_MUL, FR_BOX, FR_PUSH
   } front_state_type;

   function automatic logic [4:0] eff_dim(input logic [4:0] v, input int maxv);
      logic [4:0] r;
      r = v;
      if (v == 5'd0) r = 5'd1;
      else if (int'(v) > maxv) r = 5'(maxv);
      return r;
   endfunction
endpackage

// ----- rtl/core/tbv_front.sv -----
// Front end: takes a request, maps vertices to grid coordinates one per cycle
// through a shared multiplier, forms and clamps the box. Uses tbv_pkg.
`timescale 1ns / 1ps
module tbv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tbv_pkg::req_type_type req_type,
   input  logic signed [31:0]    vtx [9],
   input  logic [11:0]           query_index,
   input  logic signed [31:0]    origin [3],
   input  logic [31:0]           inv_cell,
   input  logic [4:0]            dims [3],
   output logic                  push,
   output tbv_pkg::job_type      job,
   input  logic                  full
);
   import tbv_pkg::*;

   front_state_type   state_ff, state_in;
   req_type_type      kind_ff;
   logic signed [31:0] vtx_ff [9];
   logic [11:0]        qidx_ff;
   logic [3:0]         cnt_ff;
   logic [1:0]         ax_ff;
   logic signed [32:0] rel_ff;
   logic [3:0]         rcnt_ff;
   logic               rel_v_ff;
   logic signed [33:0] g_ff [9];  // grid coordinates before clamping
   logic [31:0]        mlo_ff, mhi_ff;
   logic               mneg_ff, mv_ff;
   logic [3:0]         mcnt_ff;
   job_type            job_ff;
   logic [4:0]         dw, dh, dd;

   assign dw = eff_dim(dims[0], MaxWidth);
   assign dh = eff_dim(dims[1], MaxHeight);
   assign dd = eff_dim(dims[2], MaxDepth);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (start) state_in = (req_type == REQ_INSERT) ? FR_MUL : FR_PUSH;
         FR_MUL:  if (mv_ff && mcnt_ff == 4'd8) state_in = FR_BOX;
         FR_BOX:  state_in = FR_PUSH;
         FR_PUSH: if (!full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != FR_IDLE);
      push = (state_ff == FR_PUSH) && !full;
      job  = job_ff;
   end

   // Stage 1: subtract. Stage 2: magnitude times inverse cell size.
   // Stage 3: floor and store.
   logic [32:0] mag;
   logic [63:0] prod;
   assign mag  = rel_ff[32] ? 33'(-rel_ff) : 33'(rel_ff);
   assign prod = 64'(mag) * 64'(inv_cell);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         rel_v_ff <= 1'b0;
         mv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rel_v_ff <= (state_ff == FR_MUL) && (cnt_ff != 4'd9);
         mv_ff    <= rel_v_ff;
      end
   end

   // The axis counter runs beside the vertex counter: x, y, z, x, ...
   always_ff @(posedge clock) begin
      if (state_ff == FR_IDLE && start) begin
         kind_ff <= req_type;
         vtx_ff  <= vtx;
         qidx_ff <= query_index;
         cnt_ff  <= 4'd0;
         ax_ff   <= 2'd0;
      end else if (state_ff == FR_MUL && cnt_ff != 4'd9) begin
         cnt_ff <= cnt_ff + 4'd1;
         ax_ff  <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
      end
      rel_ff  <= 33'(vtx_ff[cnt_ff]) - 33'(origin[ax_ff]);
      rcnt_ff <= cnt_ff;
      // the high word of a 33x32 product carries the integer part
      mlo_ff  <= prod[31:0];
      mhi_ff  <= prod[63:32];
      mneg_ff <= rel_ff[32];
      mcnt_ff <= rcnt_ff;
      if (mv_ff) begin
         if (mneg_ff)
            g_ff[mcnt_ff] <= -($signed({2'b00, mhi_ff}) + 34'(mlo_ff != 32'd0));
         else
            g_ff[mcnt_ff] <= $signed({2'b00, mhi_ff});
      end
   end

   logic signed [33:0] lox, hix, loy, hiy, loz, hiz;
   always_comb begin
      lox = g_ff[0]; hix = g_ff[0];
      if (g_ff[3] < lox) lox = g_ff[3];
      if (g_ff[6] < lox) lox = g_ff[6];
      if (g_ff[3] > hix) hix = g_ff[3];
      if (g_ff[6] > hix) hix = g_ff[6];
      if (lox < 0) lox = 0;
      if (hix > $signed({29'd0, dw}) - 1) hix = $signed({29'd0, dw}) - 1;
      loy = g_ff[1]; hiy = g_ff[1];
      if (g_ff[4] < loy) loy = g_ff[4];
      if (g_ff[7] < loy) loy = g_ff[7];
      if (g_ff[4] > hiy) hiy = g_ff[4];
      if (g_ff[7] > hiy) hiy = g_ff[7];
      if (loy < 0) loy = 0;
      if (hiy > $signed({29'd0, dh}) - 1) hiy = $signed({29'd0, dh}) - 1;
      loz = g_ff[2]; hiz = g_ff[2];
      if (g_ff[5] < loz) loz = g_ff[5];
      if (g_ff[8] < loz) loz = g_ff[8];
      if (g_ff[5] > hiz) hiz = g_ff[5];
      if (g_ff[8] > hiz) hiz = g_ff[8];
      if (loz < 0) loz = 0;
      if (hiz > $signed({29'd0, dd}) - 1) hiz = $signed({29'd0, dd}) - 1;
   end

   logic [IdxW:0] wh_full;
   assign wh_full = (IdxW+1)'(dw) * (IdxW+1)'(dh);

   always_ff @(posedge clock) begin
      if (state_ff == FR_BOX || (state_ff == FR_IDLE && start)) begin
         job_ff.kind      <= (state_ff == FR_BOX) ? kind_ff : req_type;
         job_ff.empty_box <= (lox > hix) || (loy > hiy) || (loz > hiz);
         job_ff.xl <= XW'(lox); job_ff.xh <= XW'(hix);
         job_ff.yl <= YW'(loy); job_ff.yh <= YW'(hiy);
         job_ff.zl <= ZW'(loz); job_ff.zh <= ZW'(hiz);
         job_ff.w  <= (IdxW+1)'(dw);
         job_ff.wh <= wh_full;
         job_ff.qidx <= (state_ff == FR_BOX) ? qidx_ff : IdxW'(query_index);
         job_ff.qbad <= (IdxW+2)'((state_ff == FR_BOX) ? qidx_ff : query_index)
                        >= (IdxW+2)'(wh_full * dd);
      end
   end
endmodule

// ----- rtl/core/tbv_queue.sv -----
// Two-entry queue of classified jobs between front and back ends.
// Uses tbv_pkg for the job type.
`timescale 1ns / 1ps
module tbv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tbv_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             avail,
   output tbv_pkg::job_type head
);
   import tbv_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign head  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_job;
   end
endmodule

// ----- rtl/core/tbv_back.sv -----
// Back end: owns the occupancy bitmap and filled count, walks triangle boxes,
// answers queries and sweeps clears. Uses tbv_pkg.
`timescale 1ns / 1ps
module tbv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  avail,
   input  tbv_pkg::job_type      head,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic                  rsp_voxel_filled,
   output logic [12:0]           rsp_newly_set,
   output logic [12:0]           rsp_total_filled,
   output logic                  idle
);
   import tbv_pkg::*;

   // One bit per voxel: each voxel of a box is a read, then a write.
   logic            mem [StoreSize];
   logic            rd_ff;
   back_state_type  state_ff, state_in;
   job_type         job_ff;
   logic [XW-1:0]   x_ff;
   logic [YW-1:0]   y_ff;
   logic [ZW-1:0]   z_ff;
   logic [IdxW-1:0] addr_ff;
   logic [CntW-1:0] fresh_ff, total_ff;
   logic            status_ff, filled_ff;
   logic [IdxW:0]   idx_c;
   logic            last_c;
   logic            clr_busy_ff;  // clearing pass after reset, no result

   assign idx_c = (IdxW+1)'(x_ff) + (IdxW+1)'(y_ff) * job_ff.w
                  + (IdxW+1)'(z_ff) * job_ff.wh;
   assign last_c = (x_ff == job_ff.xh) && (y_ff == job_ff.yh) && (z_ff == job_ff.zh);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (avail) begin
            unique case (head.kind)
               REQ_INSERT: state_in = head.empty_box ? BK_DONE : BK_READ;
               REQ_QUERY:  state_in = head.qbad ? BK_DONE : BK_QUERY;
               REQ_CLEAR:  state_in = BK_CLEAR;
               default:    state_in = BK_DONE;
            endcase
         end
         BK_READ:  state_in = BK_WALK;
         BK_WALK:  state_in = last_c ? BK_DONE : BK_READ;
         BK_QUERY: state_in = BK_DONE;
         BK_CLEAR: if (addr_ff == IdxW'(StoreSize - 1))
            state_in = clr_busy_ff ? BK_IDLE : BK_DONE;
         BK_DONE:  state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop              = (state_ff == BK_IDLE) && avail;
      rsp_valid        = (state_ff == BK_DONE);
      rsp_status       = status_ff;
      rsp_voxel_filled = filled_ff;
      rsp_newly_set    = fresh_ff;
      rsp_total_filled = total_ff;
      idle             = (state_ff == BK_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         total_ff <= '0;
         addr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_IDLE && avail) begin
            job_ff    <= head;
            x_ff <= head.xl; y_ff <= head.yl; z_ff <= head.zl;
            fresh_ff  <= '0;
            filled_ff <= 1'b0;
            status_ff <= (head.kind == REQ_INSERT && head.empty_box)
                         || (head.kind == REQ_QUERY && head.qbad);
            addr_ff   <= '0;
         end
         if (state_ff == BK_WALK) begin
            if (!rd_ff) begin
               fresh_ff <= fresh_ff + CntW'(1);
               total_ff <= total_ff + CntW'(1);
            end
            if (z_ff != job_ff.zh) z_ff <= z_ff + ZW'(1);
            else begin
               z_ff <= job_ff.zl;
               if (y_ff != job_ff.yh) y_ff <= y_ff + YW'(1);
               else begin
                  y_ff <= job_ff.yl;
                  x_ff <= x_ff + XW'(1);
               end
            end
         end
         if (state_ff == BK_QUERY) filled_ff <= rd_ff;
         if (state_ff == BK_CLEAR) begin
            addr_ff  <= addr_ff + IdxW'(1);
            total_ff <= '0;
            if (addr_ff == IdxW'(StoreSize - 1)) clr_busy_ff <= 1'b0;
         end
      end
   end

   // Memory: one read port, one write port, registered read.
   logic [IdxW-1:0] raddr;
   always_comb begin
      raddr = (state_ff == BK_QUERY || (state_ff == BK_IDLE)) ? head.qidx : IdxW'(idx_c);
      if (state_ff == BK_READ) raddr = IdxW'(idx_c);
   end
   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (state_ff == BK_CLEAR) mem[addr_ff] <= 1'b0;
      else if (state_ff == BK_WALK && idx_c < (IdxW+1)'(StoreSize))
         mem[IdxW'(idx_c)] <= 1'b1;
   end
endmodule

// ----- rtl/core/triangle_bbox_voxelizer_core.sv -----
// Top level of the triangle bounding-box voxelizer: configuration registers,
// front end, job queue and back end. Uses tbv_pkg and the tbv_* modules.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake
//  req_*     in         start && !busy accepts one item
//  rsp_*     out        rsp_valid marks one item for one cycle, never stalled
//  csr_*     in         csr_valid && csr_ready writes one register
//
// A triangle keeps the front end busy for nine vertex products through one
// multiplier, then the box; in the back end each voxel of its box is a read
// then a write of the bitmap. A clear sweeps all 4096 bits, one a cycle.
// After reset the back end runs the same clearing pass; items are taken into
// the queue meanwhile and served after it.
module triangle_bbox_voxelizer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_v0_x,
   input  logic signed [31:0] req_v0_y,
   input  logic signed [31:0] req_v0_z,
   input  logic signed [31:0] req_v1_x,
   input  logic signed [31:0] req_v1_y,
   input  logic signed [31:0] req_v1_z,
   input  logic signed [31:0] req_v2_x,
   input  logic signed [31:0] req_v2_y,
   input  logic signed [31:0] req_v2_z,
   input  logic [11:0]        req_query_index,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic               rsp_voxel_filled,
   output logic [12:0]        rsp_newly_set,
   output logic [12:0]        rsp_total_filled,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import tbv_pkg::*;

   logic signed [31:0] origin_ff [3];
   logic [31:0]        inv_ff;
   logic [4:0]         dims_ff [3];
   logic signed [31:0] vtx [9];
   logic               push, full, pop, avail, back_idle;
   job_type            push_job, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0; origin_ff[1] <= '0; origin_ff[2] <= '0;
         inv_ff <= 32'd65536;
         dims_ff[0] <= 5'd16; dims_ff[1] <= 5'd16; dims_ff[2] <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_ff[0] <= csr_data;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_data;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_data;
            CSR_INV_CELL: inv_ff       <= csr_data;
            CSR_WIDTH:    dims_ff[0]   <= csr_data[4:0];
            CSR_HEIGHT:   dims_ff[1]   <= csr_data[4:0];
            CSR_DEPTH:    dims_ff[2]   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign vtx = '{req_v0_x, req_v0_y, req_v0_z, req_v1_x, req_v1_y, req_v1_z,
                  req_v2_x, req_v2_y, req_v2_z};

   tbv_front u_front (
      .clock, .reset, .start, .busy,
      .req_type(req_type_type'(req_type)), .vtx, .query_index(req_query_index),
      .origin(origin_ff), .inv_cell(inv_ff), .dims(dims_ff),
      .push, .job(push_job), .full
   );

   tbv_queue u_queue (
      .clock, .reset, .push, .push_job, .full, .pop, .avail, .head
   );

   tbv_back u_back (
      .clock, .reset, .avail, .head, .pop,
      .rsp_valid, .rsp_status, .rsp_voxel_filled, .rsp_newly_set,
      .rsp_total_filled, .idle(back_idle)
   );

`ifndef ASSERT_OFF
   // A result never reports new voxels together with a failed status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_newly_set == '0)
      else $error("new voxels reported on failed request");
   // The queue is never pushed while full.
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   // Two results never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");
   // The back end is never idle while it presents a result.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !back_idle)
      else $error("result while back end idle");
`endif
endmodule

// ----- dv/tbv_checker.sv -----
// Scoreboard for the triangle bounding-box voxelizer: watches the request,
// result and register channels, keeps its own bitmap and compares results.
// Depends on tbv_pkg for the request and register codes.
`timescale 1ns / 1ps
module tbv_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_v0_x,
   input  logic signed [31:0] req_v0_y,
   input  logic signed [31:0] req_v0_z,
   input  logic signed [31:0] req_v1_x,
   input  logic signed [31:0] req_v1_y,
   input  logic signed [31:0] req_v1_z,
   input  logic signed [31:0] req_v2_x,
   input  logic signed [31:0] req_v2_y,
   input  logic signed [31:0] req_v2_z,
   input  logic [11:0]        req_query_index,
   input  logic               rsp_valid,
   input  logic               rsp_status,
   input  logic               rsp_voxel_filled,
   input  logic [12:0]        rsp_newly_set,
   input  logic [12:0]        rsp_total_filled,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 errors,
   output int                 outstanding
);
   import tbv_pkg::*;

   typedef struct {
      logic        status;
      logic        filled;
      logic [12:0] newly;
      logic [12:0] total;
   } voxel_result_type;

   voxel_result_type pending_results[$];

   logic [31:0] org_x, org_y, org_z, inv_cell;
   logic [4:0]  dim_w, dim_h, dim_d;
   logic        occupied[StoreSize];
   logic [12:0] filled_total;

   assign outstanding = pending_results.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Exact floor((p - o) * inv / 2^32); the product magnitude fits in 64 bits.
   function automatic longint cell_of(input logic [31:0] p, input logic [31:0] o);
      longint      rel;
      logic [63:0] mag, prod;
      longint      q;
      rel  = longint'($signed(p)) - longint'($signed(o));
      mag  = (rel < 0) ? 64'(-rel) : 64'(rel);
      prod = mag * {32'd0, inv_cell};
      q    = longint'(prod >> 32);
      if (rel < 0) begin
         if (prod[31:0] != 0) q++;
         return -q;
      end
      return q;
   endfunction

   function automatic bit axis_span(input longint a, input longint b, input longint c,
                                    input int dim, output int lo, output int hi);
      longint mn, mx;
      mn = a; mx = a;
      if (b < mn) mn = b;
      if (c < mn) mn = c;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      if (mn < 0) mn = 0;
      if (mx > dim - 1) mx = dim - 1;
      lo = int'(mn);
      hi = int'(mx);
      return mn <= mx;
   endfunction

   task automatic predict_voxels();
      voxel_result_type r;
      int w, h, d, xl, xh, yl, yh, zl, zh, idx, fresh;
      bit ok;
      w = eff_dim(dim_w, MaxWidth);
      h = eff_dim(dim_h, MaxHeight);
      d = eff_dim(dim_d, MaxDepth);
      r = '{1'b0, 1'b0, 13'd0, 13'd0};
      fresh = 0;
      case (req_type)
         REQ_INSERT: begin
            ok = axis_span(cell_of(req_v0_x, org_x), cell_of(req_v1_x, org_x),
                           cell_of(req_v2_x, org_x), w, xl, xh);
            ok = axis_span(cell_of(req_v0_y, org_y), cell_of(req_v1_y, org_y),
                           cell_of(req_v2_y, org_y), h, yl, yh) && ok;
            ok = axis_span(cell_of(req_v0_z, org_z), cell_of(req_v1_z, org_z),
                           cell_of(req_v2_z, org_z), d, zl, zh) && ok;
            if (!ok) r.status = 1'b1;
            else begin
               for (int x = xl; x <= xh; x++)
                  for (int y = yl; y <= yh; y++)
                     for (int z = zl; z <= zh; z++) begin
                        idx = x + y * w + z * w * h;
                        if (idx < StoreSize && !occupied[idx]) begin
                           occupied[idx] = 1'b1;
                           fresh++;
                           filled_total++;
                        end
                     end
            end
         end
         REQ_QUERY: begin
            if (int'(req_query_index) >= w * h * d) r.status = 1'b1;
            else r.filled = occupied[req_query_index];
         end
         REQ_CLEAR: begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            filled_total = '0;
         end
         default: ;
      endcase
      r.newly = 13'(fresh);
      r.total = filled_total;
      pending_results.push_back(r);
   endtask

   always @(posedge clock) begin
      voxel_result_type want;
      if (reset) begin
         org_x = '0; org_y = '0; org_z = '0;
         inv_cell = 32'd65536;
         dim_w = 5'd16; dim_h = 5'd16; dim_d = 5'd16;
         foreach (occupied[i]) occupied[i] = 1'b0;
         filled_total = '0;
         pending_results.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X: org_x = csr_data;
               CSR_ORIGIN_Y: org_y = csr_data;
               CSR_ORIGIN_Z: org_z = csr_data;
               CSR_INV_CELL: inv_cell = csr_data;
               CSR_WIDTH:    dim_w = csr_data[4:0];
               CSR_HEIGHT:   dim_h = csr_data[4:0];
               CSR_DEPTH:    dim_d = csr_data[4:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("[%0t] result item with nothing expected", $realtime);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_voxel_filled !== want.filled)
                  report_mismatch("voxel_filled", rsp_voxel_filled, want.filled);
               if (rsp_newly_set !== want.newly)
                  report_mismatch("newly_set", rsp_newly_set, want.newly);
               if (rsp_total_filled !== want.total)
                  report_mismatch("total_filled", rsp_total_filled, want.total);
            end
         end
         if (start && !busy) predict_voxels();
      end
   end
endmodule

// ----- dv/triangle_bbox_voxelizer_core_tb.sv -----
// Top of the voxelizer testbench: clock, reset, request and register stimulus,
// watchdog and verdict. Depends on tbv_pkg, tbv_checker and the core RTL.
`timescale 1ns / 1ps
module triangle_bbox_voxelizer_core_tb;
   import tbv_pkg::*;

   localparam int StallLimit = 60000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_type = REQ_NOP;
   logic [31:0]       vtx[9];
   logic [11:0]       req_query_index = '0;
   logic              rsp_valid, rsp_status, rsp_voxel_filled;
   logic [12:0]       rsp_newly_set, rsp_total_filled;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = CSR_NONE;
   logic [31:0]       csr_data = '0;
   int                errors, outstanding;

   // The generator keeps its own view of the grid so that most triangles land
   // near it; the checker does not rely on this copy.
   logic [31:0] cur_org[3];
   logic [31:0] cur_inv;
   int          cur_dim[3];

   int sender_idle_pct = 0;
   int n_insert = 0, n_query = 0, n_clear = 0, n_other = 0;
   int stall_cycles = 0;

   initial foreach (vtx[i]) vtx[i] = '0;

   always #10 clock = ~clock;

   triangle_bbox_voxelizer_core dut (
      .clock, .reset, .start, .busy, .req_type,
      .req_v0_x(vtx[0]), .req_v0_y(vtx[1]), .req_v0_z(vtx[2]),
      .req_v1_x(vtx[3]), .req_v1_y(vtx[4]), .req_v1_z(vtx[5]),
      .req_v2_x(vtx[6]), .req_v2_y(vtx[7]), .req_v2_z(vtx[8]),
      .req_query_index, .rsp_valid, .rsp_status, .rsp_voxel_filled,
      .rsp_newly_set, .rsp_total_filled, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   tbv_checker u_checker (
      .clock, .reset, .start, .busy, .req_type,
      .req_v0_x(vtx[0]), .req_v0_y(vtx[1]), .req_v0_z(vtx[2]),
      .req_v1_x(vtx[3]), .req_v1_y(vtx[4]), .req_v1_z(vtx[5]),
      .req_v2_x(vtx[6]), .req_v2_y(vtx[7]), .req_v2_z(vtx[8]),
      .req_query_index, .rsp_valid, .rsp_status, .rsp_voxel_filled,
      .rsp_newly_set, .rsp_total_filled, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .outstanding
   );

   // The watchdog counts cycles in which no channel moves an item. The longest
   // honest gap is a full-grid triangle or a clear.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("watchdog expired after %0d idle cycles", StallLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Register writes happen only while the block is idle.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ORIGIN_X: cur_org[0] = data;
         CSR_ORIGIN_Y: cur_org[1] = data;
         CSR_ORIGIN_Z: cur_org[2] = data;
         CSR_INV_CELL: cur_inv = data;
         CSR_WIDTH:    cur_dim[0] = eff_dim(data[4:0], MaxWidth);
         CSR_HEIGHT:   cur_dim[1] = eff_dim(data[4:0], MaxHeight);
         CSR_DEPTH:    cur_dim[2] = eff_dim(data[4:0], MaxDepth);
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [31:0] ox, oy, oz, inv,
                           input logic [4:0] w, h, d);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_INV_CELL, inv);
      write_reg(CSR_WIDTH, {27'd0, w});
      write_reg(CSR_HEIGHT, {27'd0, h});
      write_reg(CSR_DEPTH, {27'd0, d});
   endtask

   // Called at a falling edge. Busy only changes at rising edges, so its value
   // here is the one the next rising edge sees; the item is taken there.
   task automatic send_item(input req_type_type kind, input logic [11:0] qidx);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_type        <= kind;
      req_query_index <= qidx;
      start           <= 1'b1;
      #1;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      case (kind)
         REQ_INSERT: n_insert++;
         REQ_QUERY:  n_query++;
         REQ_CLEAR:  n_clear++;
         default:    n_other++;
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // A coordinate that maps into grid cell g (plus a random fraction) on axis a.
   function automatic logic [31:0] point_in_cell(input int a, input int g);
      longint num;
      num = (longint'(g) <<< 32) + longint'($urandom());
      return cur_org[a] + 32'(num / longint'(cur_inv));
   endfunction

   task automatic make_triangle(input bit wide);
      int lo, span;
      for (int a = 0; a < 3; a++) begin
         lo   = wide ? -3 : $urandom_range(cur_dim[a] + 1) - 2;
         span = wide ? cur_dim[a] + 6 : $urandom_range(3);
         for (int v = 0; v < 3; v++)
            vtx[v * 3 + a] <= point_in_cell(a, lo + $urandom_range(span));
      end
   endtask

   task automatic random_item();
      int pick, vol;
      pick = $urandom_range(99);
      vol  = cur_dim[0] * cur_dim[1] * cur_dim[2];
      if (pick < 58) begin
         make_triangle($urandom_range(99) < 3);
         send_item(REQ_INSERT, 12'($urandom()));
      end else if (pick < 70) begin
         foreach (vtx[i]) vtx[i] <= $urandom();
         send_item(REQ_INSERT, 12'($urandom()));
      end else if (pick < 95) begin
         foreach (vtx[i]) vtx[i] <= $urandom();
         if ($urandom_range(99) < 80) send_item(REQ_QUERY, 12'($urandom_range(vol - 1)));
         else send_item(REQ_QUERY, 12'($urandom()));
      end else if (pick < 98) begin
         send_item(REQ_CLEAR, 12'($urandom()));
      end else begin
         send_item(REQ_NOP, 12'($urandom()));
      end
   endtask

   initial begin
      cur_org = '{32'd0, 32'd0, 32'd0};
      cur_inv = 32'd65536;
      cur_dim = '{16, 16, 16};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset grid: 16 by 16 by 16 cubes of 1 mm at the origin.
      send_item(REQ_QUERY, 12'd0);
      make_triangle(1'b0);
      send_item(REQ_INSERT, 12'd0);
      send_item(REQ_INSERT, 12'd0);               // same box again sets nothing
      vtx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0};
      send_item(REQ_INSERT, 12'd0);               // box spans the whole grid
      send_item(REQ_QUERY, 12'd4095);
      send_item(REQ_QUERY, 12'd0);
      send_item(REQ_CLEAR, 12'hFFF);
      send_item(REQ_QUERY, 12'd4095);
      // Box entirely below the grid on x: nothing is set.
      vtx = '{32'hFFFF_0000, 0, 0, 32'hFFF0_0000, 0, 0, 32'h8000_0000, 0, 0};
      send_item(REQ_INSERT, 12'd0);
      // Box entirely beyond the grid on z.
      vtx = '{0, 0, 32'h0010_0000, 0, 0, 32'h0011_0000, 0, 0, 32'h7FFF_FFFF};
      send_item(REQ_INSERT, 12'd0);
      send_item(REQ_NOP, 12'd0);
      vtx = '{32'h0000_8000, 32'h0001_8000, 32'h0002_8000,
              32'h0000_8000, 32'h0001_8000, 32'h0002_8000,
              32'h0000_8000, 32'h0001_8000, 32'h0002_8000};
      send_item(REQ_INSERT, 12'd0);               // degenerate triangle, one voxel
      send_item(REQ_QUERY, 12'(0 + 1 * 16 + 2 * 256));
      wait_idle();

      // A smaller grid with bits still set: they keep their linear indices.
      set_grid(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'd131072, 5'd4, 5'd3, 5'd2);
      send_item(REQ_QUERY, 12'd23);
      send_item(REQ_QUERY, 12'd24);               // first index past the grid
      make_triangle(1'b1);
      send_item(REQ_INSERT, 12'd0);
      send_item(REQ_QUERY, 12'd5);
      wait_idle();
      write_reg(CSR_NONE, 32'hFFFF_FFFF);          // unused index changes nothing
      wait_idle();

      // Random phases, each with its own grid setting.
      for (int phase = 0; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 71 : 0;
         case (phase)
            0: set_grid(0, 0, 0, 32'd65536, 5'd16, 5'd16, 5'd16);
            1: set_grid(32'h8000_0000, 32'h7FFF_FFFF, $urandom(), 32'hFFFF_FFFF,
                        5'd0, 5'd31, 5'd1);
            2: set_grid($urandom(), $urandom(), $urandom(), 32'd1, 5'd5, 5'd7, 5'd3);
            3: set_grid($urandom(), $urandom(), $urandom(), $urandom_range(1 << 20, 1 << 12),
                        5'($urandom_range(16, 1)), 5'($urandom_range(16, 1)),
                        5'($urandom_range(16, 1)));
            4: set_grid($urandom(), $urandom(), $urandom(), 32'd196608, 5'd16, 5'd1, 5'd16);
            default: set_grid($urandom(), $urandom(), $urandom(),
                              $urandom_range(1 << 22, 1 << 10), 5'($urandom()),
                              5'($urandom()), 5'($urandom()));
         endcase
         repeat (115) random_item();
         wait_idle();
      end

      $display("covered %0d triangles, %0d queries, %0d clears and %0d no-ops",
               n_insert, n_query, n_clear, n_other);
      $display("over eight grid settings, with the sender idling at 23, 71 and 0 percent");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
